// ===== rtl/core/gpe_pkg.sv =====
// Package with the shared types and constants of the GPIO edge-interrupt port.
package gpe_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned INDEX_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 3'd0,
    FUNC_SET        = 3'd1,
    FUNC_CLR        = 3'd2,
    FUNC_WRITE      = 3'd3,
    FUNC_RD_PINS    = 3'd4,
    FUNC_RD_RISE    = 3'd5,
    FUNC_RD_FALL    = 3'd6,
    FUNC_CLR_STATUS = 3'd7
  } func_t;

  localparam logic [INDEX_W-1:0] CFG_IDX_DIR     = 2'd0;
  localparam logic [INDEX_W-1:0] CFG_IDX_RISE_EN = 2'd1;
  localparam logic [INDEX_W-1:0] CFG_IDX_FALL_EN = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] direction_mask;
    logic [DATA_W-1:0] rise_enable;
    logic [DATA_W-1:0] fall_enable;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] drive_level;
    logic [DATA_W-1:0] drive_enable;
    logic              irq_pending;
  } res_t;

endpackage

// ===== rtl/core/gpe_if.sv =====
// Channel interfaces for the input, result and configuration ports.
interface gpe_in_if;
  logic                         valid;
  logic                         ready;
  gpe_pkg::func_t               func;
  logic [gpe_pkg::DATA_W-1:0]   pin_levels;
  logic [gpe_pkg::DATA_W-1:0]   write_data;

  modport source(output valid, func, pin_levels, write_data, input ready);
  modport sink(input valid, func, pin_levels, write_data, output ready);
endinterface

interface gpe_out_if;
  logic                         valid;
  logic                         ready;
  logic [gpe_pkg::DATA_W-1:0]   read_data;
  logic [gpe_pkg::DATA_W-1:0]   drive_level;
  logic [gpe_pkg::DATA_W-1:0]   drive_enable;
  logic                         irq_pending;

  modport source(output valid, read_data, drive_level, drive_enable, irq_pending,
                 input ready);
  modport sink(input valid, read_data, drive_level, drive_enable, irq_pending,
               output ready);
endinterface

interface gpe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gpe_pkg::INDEX_W-1:0]  index;
  logic [gpe_pkg::DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/gpe_cfg.sv =====
// Configuration registers: direction mask and the rise and fall edge enables.
module gpe_cfg #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  gpe_cfg_if.sink         cfg_bus,
  output gpe_pkg::cfg_t   cfg
);

  logic [PIN_COUNT-1:0] dir_r, rise_en_r, fall_en_r;
  logic                 wr_en;

  assign cfg_bus.ready = 1'b1;
  assign wr_en         = cfg_bus.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= '0;
      rise_en_r <= '0;
      fall_en_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_bus.index)
        gpe_pkg::CFG_IDX_DIR:     dir_r     <= cfg_bus.data[PIN_COUNT-1:0];
        gpe_pkg::CFG_IDX_RISE_EN: rise_en_r <= cfg_bus.data[PIN_COUNT-1:0];
        gpe_pkg::CFG_IDX_FALL_EN: fall_en_r <= cfg_bus.data[PIN_COUNT-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.direction_mask = gpe_pkg::DATA_W'(dir_r);
  assign cfg.rise_enable    = gpe_pkg::DATA_W'(rise_en_r);
  assign cfg.fall_enable    = gpe_pkg::DATA_W'(fall_en_r);

endmodule

// ===== rtl/core/gpe_exec.sv =====
// Port state and the single-pass update that forms one result per accepted beat.
module gpe_exec #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_acc,
  input  gpe_pkg::func_t              func,
  input  logic [gpe_pkg::DATA_W-1:0]  pin_levels,
  input  logic [gpe_pkg::DATA_W-1:0]  write_data,
  input  gpe_pkg::cfg_t               cfg,
  output gpe_pkg::res_t               res
);

  logic [PIN_COUNT-1:0] latch_r, sample_r, rise_r, fall_r;
  logic [PIN_COUNT-1:0] latch_nxt, sample_nxt, rise_nxt, fall_nxt;
  logic [PIN_COUNT-1:0] levels, data, dir, rd;

  assign levels = pin_levels[PIN_COUNT-1:0];
  assign data   = write_data[PIN_COUNT-1:0];
  assign dir    = cfg.direction_mask[PIN_COUNT-1:0];

  always_comb begin
    latch_nxt  = latch_r;
    sample_nxt = sample_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    rd         = '0;
    unique case (func)
      gpe_pkg::FUNC_TICK: begin
        rise_nxt   = rise_r | (~sample_r & levels & cfg.rise_enable[PIN_COUNT-1:0]);
        fall_nxt   = fall_r | (sample_r & ~levels & cfg.fall_enable[PIN_COUNT-1:0]);
        sample_nxt = levels;
      end
      gpe_pkg::FUNC_SET:     latch_nxt = latch_r | data;
      gpe_pkg::FUNC_CLR:     latch_nxt = latch_r & ~data;
      gpe_pkg::FUNC_WRITE:   latch_nxt = data;
      gpe_pkg::FUNC_RD_PINS: rd = (latch_r & dir) | (sample_r & ~dir);
      gpe_pkg::FUNC_RD_RISE: rd = rise_r;
      gpe_pkg::FUNC_RD_FALL: rd = fall_r;
      gpe_pkg::FUNC_CLR_STATUS: begin
        rise_nxt = rise_r & ~data;
        fall_nxt = fall_r & ~data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r  <= '0;
      sample_r <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
    end else if (in_acc) begin
      latch_r  <= latch_nxt;
      sample_r <= sample_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
    end
  end

  assign res.read_data    = gpe_pkg::DATA_W'(rd);
  assign res.drive_level  = gpe_pkg::DATA_W'(latch_nxt);
  assign res.drive_enable = cfg.direction_mask;
  assign res.irq_pending  = |(rise_nxt | fall_nxt);

endmodule

// ===== rtl/core/gpe_skid.sv =====
// Result register with a skid stage, so a beat is taken while a result waits.
module gpe_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gpe_pkg::res_t   push_data,
  output logic            push_ready,
  gpe_out_if.source       out_bus
);

  gpe_pkg::res_t main_r, skid_r;
  logic          main_valid_r, skid_valid_r;
  logic          pop;

  assign push_ready = !skid_valid_r;
  assign pop        = main_valid_r && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign out_bus.valid        = main_valid_r;
  assign out_bus.read_data    = main_r.read_data;
  assign out_bus.drive_level  = main_r.drive_level;
  assign out_bus.drive_enable = main_r.drive_enable;
  assign out_bus.irq_pending  = main_r.irq_pending;

endmodule

// ===== rtl/core/gpio_port_edge_interrupt.sv =====
// Top level of the GPIO port with edge-detect interrupt status.
//
// Channels: in_bus takes one command beat (func, pin_levels, write_data);
// out_bus returns exactly one result beat per command, in order, carrying
// the read data, the output latch, the output enables and the interrupt
// flag as they stand after that command. cfg_bus writes the direction mask
// (index 0), rise enable (1) and fall enable (2); other indexes are ignored.
// cfg_bus is always ready; the user must write it only while no command is in
// flight, as the block itself does not enforce this. A command accepted at an
// edge is written into the result register at that same edge when that register
// is free or being emptied, so its result beat is on out_bus right after the edge.
// Throughput: one command per cycle while in_bus.ready is high, set by the
// single pass of masked logic between the command port and the result register.
// Stall: a two-entry output buffer (result register plus skid register)
// keeps in_bus ready while one result waits; in_bus.ready drops only when
// both entries are full.
// Reset: rst_n (synchronous, active low) clears the configuration, the
// output latch, the last sample and both status words, and empties the
// output buffer. Pins at and above PIN_COUNT always read as zero.
module gpio_port_edge_interrupt #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  gpe_in_if.sink     in_bus,
  gpe_out_if.source  out_bus,
  gpe_cfg_if.sink    cfg_bus
);

  gpe_pkg::cfg_t cfg;
  gpe_pkg::res_t res;
  logic          in_acc;
  logic          push_ready;

  assign in_bus.ready = push_ready;
  assign in_acc       = in_bus.valid && push_ready;

  gpe_cfg #(.PIN_COUNT(PIN_COUNT)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  gpe_exec #(.PIN_COUNT(PIN_COUNT)) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .func       (in_bus.func),
    .pin_levels (in_bus.pin_levels),
    .write_data (in_bus.write_data),
    .cfg        (cfg),
    .res        (res)
  );

  gpe_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc),
    .push_data  (res),
    .push_ready (push_ready),
    .out_bus    (out_bus)
  );

endmodule

// ===== rtl/core/gpe_checker.sv =====
// Port-level assertions for the GPIO port and the bind that attaches them.
module gpe_checker #(
  parameter int unsigned PIN_COUNT = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [gpe_pkg::FUNC_W-1:0]  in_func,
  input logic [gpe_pkg::DATA_W-1:0]  in_write_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gpe_pkg::DATA_W-1:0]  out_read_data,
  input logic [gpe_pkg::DATA_W-1:0]  out_drive_level
);

  localparam logic [gpe_pkg::DATA_W-1:0] PIN_MASK =
    gpe_pkg::DATA_W'({PIN_COUNT{1'b1}});

  logic in_acc;
  logic no_read;

  assign in_acc  = in_valid && in_ready;
  assign no_read = (in_func == gpe_pkg::FUNC_TICK) || (in_func == gpe_pkg::FUNC_SET) ||
                   (in_func == gpe_pkg::FUNC_CLR) || (in_func == gpe_pkg::FUNC_WRITE) ||
                   (in_func == gpe_pkg::FUNC_CLR_STATUS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid |=> out_valid)
    else $error("Result did not appear one cycle after the command beat.");

  a_write_latch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid && (in_func == gpe_pkg::FUNC_WRITE)
      |=> out_drive_level == ($past(in_write_data) & PIN_MASK))
    else $error("Latch write not reflected in drive_level.");

  a_no_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid && no_read |=> out_read_data == '0)
    else $error("Nonzero read_data for a command that reads nothing.");

endmodule

bind gpio_port_edge_interrupt gpe_checker #(.PIN_COUNT(PIN_COUNT)) u_gpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .in_func         (in_bus.func),
  .in_write_data   (in_bus.write_data),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_read_data   (out_bus.read_data),
  .out_drive_level (out_bus.drive_level)
);
